>>> design/blp_pkg.sv
// Shared constants, types and helpers for the Bresenham line pixel core.
package blp_pkg;

    localparam int COORD_BITS    = 10;
    localparam int ERR_BITS      = COORD_BITS + 1;
    localparam int SCREEN_BITS   = 10;
    localparam int COLOR_BITS    = 24;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = COLOR_BITS;
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(256);
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(160);

    typedef logic [COORD_BITS-1:0]  coord_t;
    typedef logic [ERR_BITS-1:0]    err_t;
    typedef logic [SCREEN_BITS-1:0] screen_t;
    typedef logic [COLOR_BITS-1:0]  color_t;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_ADDR_BITS-1:0]
    {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_DRAW_COLOR    = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        cmd_t   cmd;
        coord_t x_start;
        coord_t y_start;
        coord_t x_end;
        coord_t y_end;
    } item_t;

    typedef struct packed
    {
        screen_t screen_width;
        screen_t screen_height;
        color_t  draw_color;
    } cfg_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } pixel_t;

    function automatic coord_t step_coord(coord_t v, logic down);
        return down ? (v - coord_t'(1)) : (v + coord_t'(1));
    endfunction

endpackage

>>> design/blp_cfg_regs.sv
// Configuration registers: screen width, screen height and draw color.
module blp_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [blp_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [blp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    output blp_pkg::cfg_t                        cfg
);
    import blp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[SCREEN_BITS-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[SCREEN_BITS-1:0];
                REG_DRAW_COLOR:    cfg_next.draw_color    = cfg_wdata[COLOR_BITS-1:0];
                default:           cfg_next = cfg_reg;  // unknown index: drop write
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RESET;
            cfg_reg.draw_color    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/blp_line_engine.sv
// Line state, loaded by a start item, and one Bresenham step per processed step item.
module blp_line_engine
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           process,
    input  blp_pkg::item_t item,
    input  blp_pkg::cfg_t  cfg,
    output logic           emit,
    output blp_pkg::pixel_t pixel
);
    import blp_pkg::*;

    coord_t cur_x_reg,       cur_x_next;
    coord_t cur_y_reg,       cur_y_next;
    err_t   err_acc_reg,     err_acc_next;
    coord_t err_den_reg,     err_den_next;
    coord_t err_add_reg,     err_add_next;
    coord_t pixels_left_reg, pixels_left_next;
    logic   line_active_reg, line_active_next;
    logic   x_decreasing_reg, x_decreasing_next;
    logic   y_decreasing_reg, y_decreasing_next;
    logic   x_major_reg,     x_major_next;

    logic   is_start;
    logic   is_step;
    logic   x_dec;
    logic   y_dec;
    coord_t dx;
    coord_t dy;
    logic   xm;
    coord_t den;
    err_t   err_sum;
    logic   err_over;
    err_t   err_upd;
    coord_t step_x;
    coord_t step_y;

    assign is_start = process && (item.cmd == CMD_START);
    assign is_step  = process && (item.cmd == CMD_STEP) && line_active_reg;

    // Endpoint setup
    assign x_dec = item.x_end < item.x_start;
    assign y_dec = item.y_end < item.y_start;
    assign dx    = x_dec ? (item.x_start - item.x_end) : (item.x_end - item.x_start);
    assign dy    = y_dec ? (item.y_start - item.y_end) : (item.y_end - item.y_start);
    assign xm    = dx >= dy;
    assign den   = xm ? dx : dy;

    // Error term advance, reduced by the major-axis delta when it overflows
    assign err_sum  = err_acc_reg + {1'b0, err_add_reg};
    assign err_over = err_sum >= {1'b0, err_den_reg};
    assign err_upd  = err_over ? (err_sum - {1'b0, err_den_reg}) : err_sum;

    always_comb
    begin
        step_x = cur_x_reg;
        step_y = cur_y_reg;
        if (x_major_reg)
        begin
            step_x = step_coord(cur_x_reg, x_decreasing_reg);
            if (err_over)
                step_y = step_coord(cur_y_reg, y_decreasing_reg);
        end
        else
        begin
            step_y = step_coord(cur_y_reg, y_decreasing_reg);
            if (err_over)
                step_x = step_coord(cur_x_reg, x_decreasing_reg);
        end
    end

    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        err_acc_next      = err_acc_reg;
        err_den_next      = err_den_reg;
        err_add_next      = err_add_reg;
        pixels_left_next  = pixels_left_reg;
        line_active_next  = line_active_reg;
        x_decreasing_next = x_decreasing_reg;
        y_decreasing_next = y_decreasing_reg;
        x_major_next      = x_major_reg;
        priority if (is_start)
        begin
            // a start abandons whatever line is running
            cur_x_next        = item.x_start;
            cur_y_next        = item.y_start;
            x_decreasing_next = x_dec;
            y_decreasing_next = y_dec;
            x_major_next      = xm;
            err_den_next      = den;
            err_add_next      = xm ? dy : dx;
            err_acc_next      = {1'b0, den >> 1};
            pixels_left_next  = den;
            line_active_next  = 1'b1;
        end
        else if (is_step)
        begin
            cur_x_next   = step_x;
            cur_y_next   = step_y;
            err_acc_next = err_upd;
            if (pixels_left_reg == '0)
                line_active_next = 1'b0;
            else
                pixels_left_next = pixels_left_reg - coord_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            err_acc_reg      <= '0;
            err_den_reg      <= '0;
            err_add_reg      <= '0;
            pixels_left_reg  <= '0;
            line_active_reg  <= 1'b0;
            x_decreasing_reg <= 1'b0;
            y_decreasing_reg <= 1'b0;
            x_major_reg      <= 1'b0;
        end
        else
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            err_acc_reg      <= err_acc_next;
            err_den_reg      <= err_den_next;
            err_add_reg      <= err_add_next;
            pixels_left_reg  <= pixels_left_next;
            line_active_reg  <= line_active_next;
            x_decreasing_reg <= x_decreasing_next;
            y_decreasing_reg <= y_decreasing_next;
            x_major_reg      <= x_major_next;
        end
    end

    // Mirror against the panel size
    assign emit              = is_step;
    assign pixel.pixel_x     = coord_t'(cfg.screen_width) - cur_x_reg;
    assign pixel.pixel_y     = coord_t'(cfg.screen_height) - cur_y_reg;
    assign pixel.pixel_color = cfg.draw_color;
    assign pixel.last_pixel  = pixels_left_reg == '0;

    a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
        is_start |=> line_active_reg)
        else $error("line not active after start");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        is_step && (pixels_left_reg == '0) |=> !line_active_reg)
        else $error("line still active after last pixel");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (err_acc_reg < {1'b0, err_den_reg}) || (err_den_reg == '0))
        else $error("error accumulator out of range");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        is_step && (pixels_left_reg != '0) |=>
            pixels_left_reg == $past(pixels_left_reg) - coord_t'(1))
        else $error("pixel count did not decrement");

endmodule

>>> design/bresenham_line_pixels_core.sv
// Bresenham line pixel core: input register, line engine and output register.
// A step item passes the input register, then the output register, on its way to m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the output; the line engine's
// single error add/compare sets it. A stalled output holds its pixel; the input register
// still takes the next item only while empty. Reset (rst_n, async, active low) drops any
// running line and pending items and loads screen width 256, height 160 and color 0.
module bresenham_line_pixels_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [blp_pkg::IN_DATA_BITS-1:0]     s_tdata,  // x_start, y_start, x_end, y_end
    input  logic                                 s_tuser,  // cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [blp_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // pixel_x, pixel_y, pixel_color
    output logic                                 m_tlast,  // last_pixel
    input  logic                                 cfg_we,
    input  logic [blp_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [blp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import blp_pkg::*;

    logic   in_valid_reg;
    logic   in_valid_next;
    item_t  in_item_reg;
    item_t  in_item_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    pixel_t out_pixel_reg;
    pixel_t out_pixel_next;

    logic   advance;
    logic   emit;
    pixel_t pixel;
    cfg_t   cfg;

    // process the held item once the output register has room for its result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            in_item_next  = '{cmd:     cmd_t'(s_tuser),
                              x_start: s_tdata[COORD_BITS-1:0],
                              y_start: s_tdata[2*COORD_BITS-1:COORD_BITS],
                              x_end:   s_tdata[3*COORD_BITS-1:2*COORD_BITS],
                              y_end:   s_tdata[4*COORD_BITS-1:3*COORD_BITS]};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        priority if (advance)
        begin
            out_valid_next = emit;
            out_pixel_next = pixel;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg   <= in_item_next;
        out_pixel_reg <= out_pixel_next;
    end

    blp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    blp_line_engine u_line_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .emit    (emit),
        .pixel   (pixel)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'({out_pixel_reg.pixel_color,
                                      out_pixel_reg.pixel_y,
                                      out_pixel_reg.pixel_x});
    assign m_tlast  = out_pixel_reg.last_pixel;

endmodule
